FILE: rtl/event_subscription_router_core_defines.svh
// ----------------------------------------------------------------------------
// Event subscription router: assertion macros
// Concurrent check helpers clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef EVENT_SUBSCRIPTION_ROUTER_CORE_DEFINES_SVH
`define EVENT_SUBSCRIPTION_ROUTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every edge outside reset
`define ESR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen outside reset
`define ESR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ESR_ASSERT(lbl, prop, msg)
`define ESR_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/esr_pkg.sv
// ----------------------------------------------------------------------------
// esr_pkg
// Shared types, sizes and codes of the event subscription router.
// ----------------------------------------------------------------------------
`default_nettype none

package esr_pkg;

  // Table and type space sizes
  localparam int SLOTS       = 16;
  localparam int EVENT_TYPES = 32;
  localparam int SLOT_IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TYPE_IDX_W  = (EVENT_TYPES > 1) ? $clog2(EVENT_TYPES) : 1;

  // Request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Request kinds on the input port
  localparam logic [1:0] KIND_SUB   = 2'd0;
  localparam logic [1:0] KIND_UNSUB = 2'd1;
  localparam logic [1:0] KIND_PUB   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADARG   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef logic [EVENT_TYPES-1:0] mask_t;
  typedef logic [SLOT_IDX_W-1:0]  sidx_t;

  typedef enum logic [1:0] {
    OP_SUB,
    OP_UNSUB,
    OP_PUB,
    OP_REJECT
  } op_t;

  // Classified request as held in the queue
  typedef struct packed {
    op_t                   op;
    logic [TYPE_IDX_W-1:0] type_idx;
    logic [31:0]           id;
    logic [31:0]           ctx;
  } cmd_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One result item
  typedef struct packed {
    logic        is_delivery;
    logic [3:0]  slot;
    logic [31:0] id;
    logic [31:0] ctx;
    logic [1:0]  status;
    logic        last;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINAL
  } bstate_t;

  // One-hot mask bit of an event type
  function automatic mask_t type_bit(input logic [TYPE_IDX_W-1:0] t);
    mask_t m;
    m    = '0;
    m[t] = 1'b1;
    return m;
  endfunction

  // Slot index as shown on the 4-bit result field
  function automatic logic [3:0] slot_out(input sidx_t s);
    logic [SLOT_IDX_W+3:0] w;
    w = {4'd0, s};
    return w[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/event_subscription_router_core.sv
// Results: an accepted request waits in the queue behind any running one, is popped,
// then scanned. Subscribe/unsubscribe stop at the matching slot, else at the last slot;
// publish reads every slot, one slot read per cycle, then gives the status item.
// Rejected requests skip the scan. Two requests can queue while one runs.
// Results cannot be held off: each shows for one cycle with strobe.
// Synchronous reset empties the queue and invalidates every table slot at once.
// ----------------------------------------------------------------------------
// event_subscription_router_core
// Subscriber table with subscribe, unsubscribe and publish requests.
// ----------------------------------------------------------------------------
`default_nettype none
`include "event_subscription_router_core_defines.svh"

module event_subscription_router_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  topic,
  input  wire logic [31:0] subscriber_id,
  input  wire logic [31:0] context_req,
  output logic             strobe,
  output logic             is_delivery,
  output logic [3:0]       slot,
  output logic [31:0]      target_id,
  output logic [31:0]      target_context,
  output logic [1:0]       status,
  output logic             last
);
  import esr_pkg::*;

  cmd_t    front_cmd;
  cmd_t    head;
  q_stat_t q_stat;
  logic    pop;
  res_t    res;
  logic    dlv_ok;
  logic    stat_ok;

  // Classify the request
  esr_front u_front (
    .kind          (kind),
    .topic         (topic),
    .subscriber_id (subscriber_id),
    .context_req   (context_req),
    .cmd           (front_cmd)
  );

  // Queue accepted requests
  esr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (start && !busy),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Carry out requests against the table
  esr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .strobe (strobe),
    .res    (res)
  );

  assign busy           = q_stat.full;
  assign is_delivery    = res.is_delivery;
  assign slot           = res.slot;
  assign target_id      = res.id;
  assign target_context = res.ctx;
  assign status         = res.status;
  assign last           = res.last;

  // Checks
  assign dlv_ok  = !last && status == ST_OK;
  assign stat_ok = last && target_id == 32'd0 && target_context == 32'd0;

  `ESR_ASSERT(a_delivery_not_last, (strobe && is_delivery) |-> dlv_ok, "bad delivery")
  `ESR_ASSERT(a_status_zero_target, (strobe && !is_delivery) |-> stat_ok, "bad status item")
  `ESR_ASSERT(a_pop_spacing, pop |=> !pop, "back end popped twice in a row")
  `ESR_NEVER(a_no_pop_empty, pop && q_stat.empty, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/esr_front.sv
// ----------------------------------------------------------------------------
// esr_front
// Classifies an incoming request and rejects bad arguments up front.
// ----------------------------------------------------------------------------
`default_nettype none

module esr_front (
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  topic,
  input  wire logic [31:0] subscriber_id,
  input  wire logic [31:0] context_req,
  output esr_pkg::cmd_t    cmd
);
  import esr_pkg::*;

  logic type_ok;
  logic id_ok;

  assign type_ok = topic < 8'(EVENT_TYPES);
  assign id_ok   = subscriber_id != 32'd0;

  // Pick the operation, folding every bad argument into a reject
  always_comb begin
    cmd.type_idx = topic[TYPE_IDX_W-1:0];
    cmd.id       = subscriber_id;
    cmd.ctx      = context_req;
    case (kind)
      KIND_SUB:   cmd.op = (id_ok && type_ok) ? OP_SUB : OP_REJECT;
      KIND_UNSUB: cmd.op = (id_ok && type_ok) ? OP_UNSUB : OP_REJECT;
      KIND_PUB:   cmd.op = type_ok ? OP_PUB : OP_REJECT;
      default:    cmd.op = OP_REJECT;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/esr_queue.sv
// ----------------------------------------------------------------------------
// esr_queue
// Short request queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module esr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire esr_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output esr_pkg::cmd_t      head,
  output esr_pkg::q_stat_t   stat
);
  import esr_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = count == QCNT_W'(QDEPTH);
  assign stat.empty = count == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/esr_back.sv
// ----------------------------------------------------------------------------
// esr_back
// Holds the subscriber table and carries out requests, one slot per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module esr_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire esr_pkg::cmd_t    head,
  input  wire esr_pkg::q_stat_t q_stat,
  output logic                  pop,
  output logic                  strobe,
  output esr_pkg::res_t         res
);
  import esr_pkg::*;

  // Subscriber table
  logic [SLOTS-1:0] slot_valid;
  logic [31:0]      slot_owner   [SLOTS];
  logic [31:0]      slot_context [SLOTS];
  mask_t            slot_type_mask [SLOTS];

  // Sequencer state
  bstate_t bstate, bstate_next;
  cmd_t    cmd, cmd_next;
  sidx_t   idx, idx_next;
  logic    free_found, free_found_next;
  sidx_t   free_idx, free_idx_next;

  // Current slot read
  logic        rv;
  logic [31:0] ro;
  logic [31:0] rc;
  mask_t       rm;
  mask_t       tbit;
  logic        at_end;
  logic        hit_sub;
  logic        hit_uns;
  logic        deliver;
  logic        done_now;

  // Table write port and result
  logic        wr_en;
  sidx_t       wr_idx;
  logic        wr_valid;
  logic [31:0] wr_owner;
  logic [31:0] wr_ctx;
  mask_t       wr_mask;
  sidx_t       claim_idx;
  mask_t       cleared;
  logic        emit;
  res_t        res_next;

  assign rv     = slot_valid[idx];
  assign ro     = slot_owner[idx];
  assign rc     = slot_context[idx];
  assign rm     = slot_type_mask[idx];
  assign tbit   = type_bit(cmd.type_idx);
  assign at_end = idx == SLOT_IDX_W'(SLOTS - 1);

  assign hit_sub  = (cmd.op == OP_SUB) && rv && (ro == cmd.id) && (rc == cmd.ctx);
  assign hit_uns  = (cmd.op == OP_UNSUB) && rv && (ro == cmd.id);
  assign deliver  = (cmd.op == OP_PUB) && rv && ((rm & tbit) != '0);
  assign done_now = hit_sub || hit_uns || (at_end && (cmd.op != OP_PUB));

  assign claim_idx = free_found ? free_idx : idx;
  assign cleared   = rm & ~tbit;

  // Next state of the sequencer
  always_comb begin
    bstate_next     = bstate;
    cmd_next        = cmd;
    idx_next        = idx;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    case (bstate)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          cmd_next        = head;
          idx_next        = '0;
          free_found_next = 1'b0;
          bstate_next     = (head.op == OP_REJECT) ? BK_FINAL : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (done_now) begin
          bstate_next = BK_IDLE;
        end else if (at_end) begin
          bstate_next = BK_FINAL;
        end else begin
          idx_next = idx + 1'b1;
          if (!rv && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = idx;
          end
        end
      end
      BK_FINAL: bstate_next = BK_IDLE;
      default:  bstate_next = BK_IDLE;
    endcase
  end

  // Results, table updates and queue pop
  always_comb begin
    pop      = (bstate == BK_IDLE) && !q_stat.empty;
    emit     = 1'b0;
    res_next = '{is_delivery: 1'b0, slot: 4'd0, id: 32'd0, ctx: 32'd0,
                 status: ST_OK, last: 1'b1};
    wr_en    = 1'b0;
    wr_idx   = idx;
    wr_valid = 1'b1;
    wr_owner = ro;
    wr_ctx   = rc;
    wr_mask  = rm;
    case (bstate)
      BK_SCAN: begin
        case (cmd.op)
          OP_SUB: begin
            if (hit_sub) begin
              emit          = 1'b1;
              res_next.slot = slot_out(idx);
              wr_en         = 1'b1;
              wr_mask       = rm | tbit;
            end else if (at_end) begin
              emit = 1'b1;
              if (free_found || !rv) begin
                res_next.slot = slot_out(claim_idx);
                wr_en         = 1'b1;
                wr_idx        = claim_idx;
                wr_owner      = cmd.id;
                wr_ctx        = cmd.ctx;
                wr_mask       = tbit;
              end else begin
                res_next.status = ST_FULL;
              end
            end
          end
          OP_UNSUB: begin
            if (hit_uns) begin
              emit          = 1'b1;
              res_next.slot = slot_out(idx);
              wr_en         = 1'b1;
              wr_mask       = cleared;
              wr_valid      = cleared != '0;
            end else if (at_end) begin
              emit            = 1'b1;
              res_next.status = ST_NOTFOUND;
            end
          end
          OP_PUB: begin
            if (deliver) begin
              emit                 = 1'b1;
              res_next.is_delivery = 1'b1;
              res_next.slot        = slot_out(idx);
              res_next.id          = ro;
              res_next.ctx         = rc;
              res_next.last        = 1'b0;
            end
          end
          default: emit = 1'b0;
        endcase
      end
      BK_FINAL: begin
        emit            = 1'b1;
        res_next.status = (cmd.op == OP_REJECT) ? ST_BADARG : ST_OK;
      end
      default: emit = 1'b0;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= BK_IDLE;
    end else begin
      bstate <= bstate_next;
    end
    cmd        <= cmd_next;
    idx        <= idx_next;
    free_found <= free_found_next;
    free_idx   <= free_idx_next;
  end

  // Table valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[wr_idx] <= wr_valid;
    end
  end

  // Table contents
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_owner[wr_idx]     <= wr_owner;
      slot_context[wr_idx]   <= wr_ctx;
      slot_type_mask[wr_idx] <= wr_mask;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
    res <= res_next;
  end

endmodule

`default_nettype wire

FILE: test/event_subscription_router_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_subscription_router_core_tb
// Drives subscribe, unsubscribe and publish requests into the router core,
// keeps a shadow subscriber table to predict every delivery and status item,
// and checks each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------

module event_subscription_router_core_tb;
  import esr_pkg::*;

  localparam logic [1:0] KIND_UNDEF = 2'd3;
  localparam int CLK_HALF    = 10;
  localparam int RESET_CYCLES = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int CALM_TAIL   = 20;
  localparam int ID_POOL_BASE = 32'h0000_0100;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  etype;
    logic [31:0] sid;
    logic [31:0] ctx;
  } req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  kind = KIND_SUB;
  logic [7:0]  topic = 8'd0;
  logic [31:0] subscriber_id = 32'd0;
  logic [31:0] context_req = 32'd0;
  logic        busy;
  logic        strobe;
  logic        is_delivery;
  logic [3:0]  slot;
  logic [31:0] target_id;
  logic [31:0] target_context;
  logic [1:0]  status;
  logic        last;

  // Shadow subscriber table
  logic        tbl_valid [SLOTS];
  logic [31:0] tbl_owner [SLOTS];
  logic [31:0] tbl_ctx   [SLOTS];
  mask_t       tbl_mask  [SLOTS];

  req_t pending_reqs[$];
  res_t expected_results[$];
  req_t next_req;

  logic taken = 1'b0;
  int   gap_left = 0;
  int   errors = 0;
  int   cycles = 0;
  int   n_accepted = 0;
  int   n_deliveries = 0;
  int   n_status = 0;

  event_subscription_router_core u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .topic          (topic),
    .subscriber_id  (subscriber_id),
    .context_req    (context_req),
    .strobe         (strobe),
    .is_delivery    (is_delivery),
    .slot           (slot),
    .target_id      (target_id),
    .target_context (target_context),
    .status         (status),
    .last           (last)
  );

  always #CLK_HALF clk = ~clk;

  // Apply one request to the shadow table and queue the results it causes
  task automatic predict_request(input req_t r);
    res_t  item;
    mask_t tbit;
    bit    type_ok;
    int    hit;
    int    i;
    type_ok = (r.etype < EVENT_TYPES);
    tbit = type_ok ? (mask_t'(1) << r.etype) : '0;
    item = '0;
    item.status = ST_OK;
    item.last = 1'b1;
    hit = -1;
    case (r.kind)
      KIND_SUB: begin
        if (r.sid == 32'd0 || !type_ok) begin
          item.status = ST_BADARG;
        end else begin
          // merge into a slot of the same id and context, else claim a free one
          for (i = 0; i < SLOTS && hit < 0; i++)
            if (tbl_valid[i] && tbl_owner[i] == r.sid && tbl_ctx[i] == r.ctx) hit = i;
          if (hit >= 0) begin
            tbl_mask[hit] |= tbit;
          end else begin
            for (i = 0; i < SLOTS && hit < 0; i++)
              if (!tbl_valid[i]) hit = i;
            if (hit >= 0) begin
              tbl_valid[hit] = 1'b1;
              tbl_owner[hit] = r.sid;
              tbl_ctx[hit]   = r.ctx;
              tbl_mask[hit]  = tbit;
            end else begin
              item.status = ST_FULL;
            end
          end
          if (hit >= 0) item.slot = hit[3:0];
        end
      end
      KIND_UNSUB: begin
        if (r.sid == 32'd0 || !type_ok) begin
          item.status = ST_BADARG;
        end else begin
          // first slot of that id, context ignored; free it once empty
          for (i = 0; i < SLOTS && hit < 0; i++)
            if (tbl_valid[i] && tbl_owner[i] == r.sid) hit = i;
          if (hit >= 0) begin
            tbl_mask[hit] &= ~tbit;
            if (tbl_mask[hit] == '0) tbl_valid[hit] = 1'b0;
            item.slot = hit[3:0];
          end else begin
            item.status = ST_NOTFOUND;
          end
        end
      end
      KIND_PUB: begin
        if (!type_ok) begin
          item.status = ST_BADARG;
        end else begin
          for (i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && (tbl_mask[i] & tbit) != '0) begin
              expected_results.push_back('{is_delivery: 1'b1, slot: i[3:0],
                                           id: tbl_owner[i], ctx: tbl_ctx[i],
                                           status: ST_OK, last: 1'b0});
            end
          end
        end
      end
      default: item.status = ST_BADARG;
    endcase
    expected_results.push_back(item);
  endtask

  task automatic add_req(input logic [1:0] k, input logic [7:0] t,
                         input logic [31:0] id, input logic [31:0] c);
    pending_reqs.push_back('{kind: k, etype: t, sid: id, ctx: c});
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Drive requests at the falling edge; hold a request until it is taken
  always @(negedge clk) begin
    if (!rst && (!start || taken)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          gap_left <= $urandom_range(0, 7);
        end else begin
          next_req = pending_reqs.pop_front();
          start <= 1'b1;
          kind <= next_req.kind;
          topic <= next_req.etype;
          subscriber_id <= next_req.sid;
          context_req <= next_req.ctx;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Predict on acceptance and check each strobed result
  always @(posedge clk) begin
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (start && !busy) begin
        n_accepted++;
        predict_request('{kind: kind, etype: topic, sid: subscriber_id,
                          ctx: context_req});
      end
      if (strobe) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual slot %h status %h",
                   $time, slot, status);
        end else begin
          res_t want;
          want = expected_results.pop_front();
          if (want.is_delivery) n_deliveries++;
          else n_status++;
          check_field("is_delivery", want.is_delivery, is_delivery);
          check_field("slot", want.slot, slot);
          check_field("target_id", want.id, target_id);
          check_field("target_context", want.ctx, target_context);
          check_field("status", want.status, status);
          check_field("last", want.last, last);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int i;
    int r;
    logic [1:0] k;
    for (i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_owner[i] = '0;
      tbl_ctx[i]   = '0;
      tbl_mask[i]  = '0;
    end

    // Directed: empty table, rejects, merge, second context, unsubscribe paths
    add_req(KIND_PUB,   8'd0,   32'h0000_0005, 32'h0);
    add_req(KIND_UNSUB, 8'd3,   32'h0000_0005, 32'h0);
    add_req(KIND_SUB,   8'd1,   32'h0000_0000, 32'h1234_5678);
    add_req(KIND_SUB,   8'd32,  32'h0000_0007, 32'h0);
    add_req(KIND_UNSUB, 8'd255, 32'h0000_0007, 32'h0);
    add_req(KIND_UNSUB, 8'd2,   32'h0000_0000, 32'h0);
    add_req(KIND_PUB,   8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(KIND_UNDEF, 8'd0,   32'h0000_0009, 32'h0);
    add_req(KIND_SUB,   8'd31,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(KIND_SUB,   8'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(KIND_SUB,   8'd31,  32'hFFFF_FFFF, 32'h0000_0000);
    add_req(KIND_PUB,   8'd31,  32'h0,         32'h0);
    add_req(KIND_PUB,   8'd0,   32'h0,         32'h0);
    add_req(KIND_UNSUB, 8'd5,   32'hFFFF_FFFF, 32'h0);
    add_req(KIND_UNSUB, 8'd31,  32'hFFFF_FFFF, 32'h0);
    add_req(KIND_PUB,   8'd31,  32'h0,         32'h0);
    add_req(KIND_UNSUB, 8'd0,   32'hFFFF_FFFF, 32'h0);
    add_req(KIND_PUB,   8'd0,   32'h0,         32'h0);
    add_req(KIND_SUB,   8'd7,   32'h8000_0001, 32'hA5A5_5A5A);
    add_req(KIND_UNSUB, 8'd7,   32'h8000_0001, 32'h0);
    add_req(KIND_PUB,   8'd31,  32'h0,         32'h0);

    // Fill the table past capacity with distinct subscribers
    for (i = 0; i < 18; i++)
      add_req(KIND_SUB, 8'($urandom_range(0, 31)), ID_POOL_BASE + i, 32'h0);

    // Mixed traffic over a small id pool, with some noise
    for (i = 0; i < 71; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        add_req(KIND_SUB,
                8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31)),
                ID_POOL_BASE + $urandom_range(0, 19), $urandom_range(0, 2));
      else if (r < 65)
        add_req(KIND_UNSUB,
                8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31)),
                ID_POOL_BASE + $urandom_range(0, 19), $urandom);
      else if (r < 90)
        add_req(KIND_PUB,
                8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31)),
                $urandom, $urandom);
      else begin
        k = 2'($urandom_range(0, 3));
        add_req(k, 8'($urandom_range(0, 255)), $urandom_range(0, 1) ? 32'd0 : $urandom,
                $urandom);
      end
    end

    // Hold reset, then release at a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last request, then for every result, then drain
    while (pending_reqs.size() > 0 || start) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d deliveries and %0d status items checked.",
             n_accepted, n_deliveries, n_status);
    $display("Mismatches or unexpected results: %0d", errors);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
